[design/rrbc_pkg.sv]
// Shared types, constants and helpers of the ROM/RAM bank controller.
// Used by rrbc_map, rrbc_ram users and the rom_ram_bank_controller top level.
package rrbc_pkg;

  localparam int unsigned RamBytes    = 32768;
  localparam int unsigned MaxRomBanks = 128;
  localparam int unsigned RamAw       = $clog2(RamBytes);
  localparam int unsigned MaxLog2     = $clog2(MaxRomBanks);
  localparam int unsigned AddrW       = 16;
  localparam int unsigned DataW       = 8;
  localparam int unsigned RomAw       = 21;
  localparam int unsigned BankW       = 7;
  localparam int unsigned LoBankW     = 5;
  localparam int unsigned CfgAw       = 4;
  localparam int unsigned ApbDw       = 32;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Register region below 0x8000 is split into four 8 KiB windows.
  typedef enum logic [1:0] {
    BANK_RAM_EN = 2'd0,
    BANK_ROM_LO = 2'd1,
    BANK_UPPER  = 2'd2,
    BANK_MODE   = 2'd3
  } bank_sel_e;

  localparam logic [1:0] REG_CART_TYPE = 2'd0;
  localparam logic [1:0] REG_ROM_BANKS = 2'd1;
  localparam logic [1:0] REG_RAM_SIZE  = 2'd2;

  localparam logic       CART_NONE = 1'b0;
  localparam logic       CART_MBC  = 1'b1;

  localparam logic [1:0] RAM_NONE = 2'd0;
  localparam logic [1:0] RAM_8K   = 2'd1;
  localparam logic [1:0] RAM_32K  = 2'd2;

  localparam logic [2:0]       RamRegionTag = 3'b101;  // 0xA000-0xBFFF
  localparam logic [3:0]       RamEnableKey = 4'hA;
  localparam logic [DataW-1:0] ByteFill     = 8'hFF;

  localparam logic       CartTypeRst = CART_MBC;
  localparam logic [2:0] RomBanksRst = 3'd1;
  localparam logic [1:0] RamSizeRst  = RAM_NONE;

  typedef struct packed {
    logic       cart_type;
    logic [2:0] rom_banks_log2;
    logic [1:0] ram_size_code;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [RamAw-1:0] addr;
    logic [DataW-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             rom_access;
    logic [RomAw-1:0] rom_address;
    logic [DataW-1:0] read_data;
    logic             unmapped;
    logic             use_ram;
  } res_t;

  // Clamp the bank count code: zero means two banks, cap at the largest ROM.
  function automatic logic [2:0] eff_log2(input logic [2:0] raw);
    logic [2:0] l;
    l = (raw == 3'd0) ? 3'd1 : raw;
    if (int'(l) > int'(MaxLog2)) begin
      l = 3'(MaxLog2);
    end
    return l;
  endfunction

endpackage

[design/rrbc_ram.sv]
// Generic single-port RAM with registered read and no reset.
// Stand-alone; holds the cartridge RAM bytes.
module rrbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rrbc_map.sv]
// Bank registers and address translation of the bank controller.
// Depends on rrbc_pkg; drives the RAM request and the per-access result.
module rrbc_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  rrbc_pkg::op_e                 op_i,
  input  logic [rrbc_pkg::AddrW-1:0]    addr_i,
  input  logic [rrbc_pkg::DataW-1:0]    data_i,
  input  rrbc_pkg::cfg_t                cfg_i,
  output rrbc_pkg::ram_req_t            ram_req_o,
  output rrbc_pkg::res_t                res_o
);
  import rrbc_pkg::*;

  logic               ram_en_q, ram_en_d;
  logic [LoBankW-1:0] lower_q, lower_d;
  logic [1:0]         upper_q, upper_d;
  logic               mode_q, mode_d;

  logic               is_mbc, ram_present, ram_ok, big, is_wr;
  logic               in_rom, in_ram, reg_wr;
  logic [2:0]         eff_l;
  logic [BankW-1:0]   bank_mask, bank;
  logic [LoBankW-1:0] lo_in;
  logic [14:0]        ram_off;
  bank_sel_e          bank_sel;

  always_comb begin
    eff_l       = eff_log2(cfg_i.rom_banks_log2);
    big         = eff_l >= 3'd6;
    is_mbc      = cfg_i.cart_type == CART_MBC;
    ram_present = cfg_i.ram_size_code inside {RAM_8K, RAM_32K};
    ram_ok      = is_mbc && ram_en_q && ram_present;
    is_wr       = op_i == OP_WRITE;
    in_rom      = !addr_i[15];
    in_ram      = addr_i[15:13] == RamRegionTag;
    bank_sel    = bank_sel_e'(addr_i[14:13]);
    reg_wr      = accept_i && is_wr && is_mbc && in_rom;

    for (int i = 0; i < int'(BankW); i++) begin
      bank_mask[i] = i < int'(eff_l);
    end
    lo_in = (data_i[LoBankW-1:0] == '0) ? LoBankW'(1) : data_i[LoBankW-1:0];

    // Lower ROM window uses only the upper bits, and only in advanced mode with at least 64 banks.
    if (!addr_i[14]) begin
      bank = (mode_q && big) ? {upper_q, {LoBankW{1'b0}}} : '0;
    end else begin
      bank = {(big ? upper_q : 2'b00), lower_q};
    end

    ram_off = (cfg_i.ram_size_code == RAM_32K && mode_q) ? {upper_q, addr_i[12:0]}
                                                          : {2'b00, addr_i[12:0]};
  end

  always_comb begin
    ram_en_d = ram_en_q;
    lower_d  = lower_q;
    upper_d  = upper_q;
    mode_d   = mode_q;
    if (reg_wr) begin
      case (bank_sel)
        BANK_RAM_EN: ram_en_d = data_i[3:0] == RamEnableKey;
        BANK_ROM_LO: lower_d  = lo_in & bank_mask[LoBankW-1:0];
        BANK_UPPER:  upper_d  = data_i[1:0];
        BANK_MODE:   mode_d   = data_i[0];
        default:     ram_en_d = ram_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q <= 1'b0;
      lower_q  <= '0;
      upper_q  <= '0;
      mode_q   <= 1'b0;
    end else begin
      ram_en_q <= ram_en_d;
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      mode_q   <= mode_d;
    end
  end

  always_comb begin
    ram_req_o.we    = accept_i && is_wr && in_ram && ram_ok;
    ram_req_o.re    = accept_i && !is_wr && in_ram && ram_ok;
    ram_req_o.addr  = ram_off[RamAw-1:0];
    ram_req_o.wdata = data_i;

    res_o.rom_access = !is_wr && in_rom;
    res_o.unmapped   = !in_rom && !in_ram;
    res_o.use_ram    = !is_wr && in_ram && ram_ok;
    if (!is_wr && in_rom) begin
      res_o.rom_address = is_mbc ? {bank & bank_mask, addr_i[13:0]}
                                 : {{(RomAw - AddrW){1'b0}}, addr_i};
    end else begin
      res_o.rom_address = '0;
    end
    res_o.read_data = (is_wr || in_rom) ? '0 : ByteFill;
  end

endmodule

[design/rom_ram_bank_controller.sv]
// Cartridge ROM/RAM bank controller: configuration, access pipeline, output register.
// Each result passes the stage register and then the output register to the master side.
// Throughput: one access per cycle unless stalled; bank writes apply to the next access.
// A RAM read lands in the RAM's own read register and holds while the stage stalls.
// Reset clears bank registers and loads configuration defaults; RAM is not cleared.
module rom_ram_bank_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrbc_pkg::CfgAw-1:0]   paddr,
  input  logic [rrbc_pkg::ApbDw-1:0]   pwdata,
  output logic [rrbc_pkg::ApbDw-1:0]   prdata,
  output logic                         pready,
  // access stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // [15:0] address, [23:16] write_data
  input  logic [0:0]                   s_axis_tuser,  // [0] operation
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // [20:0] rom_address, [28:21] read_data
  output logic [1:0]                   m_axis_tuser   // [0] rom_access, [1] unmapped
);
  import rrbc_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             cfg_wr;
  ram_req_t         ram_req;
  res_t             res, s1_res_q, out_res_q, out_res_d;
  logic             s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic             accept, s1_move;
  logic [DataW-1:0] ram_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_CART_TYPE: cfg_d.cart_type      = pwdata[0];
        REG_ROM_BANKS: cfg_d.rom_banks_log2 = pwdata[2:0];
        REG_RAM_SIZE:  cfg_d.ram_size_code  = pwdata[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CART_TYPE: prdata = ApbDw'(cfg_q.cart_type);
      REG_ROM_BANKS: prdata = ApbDw'(cfg_q.rom_banks_log2);
      REG_RAM_SIZE:  prdata = ApbDw'(cfg_q.ram_size_code);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cart_type      <= CartTypeRst;
      cfg_q.rom_banks_log2 <= RomBanksRst;
      cfg_q.ram_size_code  <= RamSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // access pipeline: translate and issue RAM access, then stage, then output
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rrbc_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_e'(s_axis_tuser[0])),
    .addr_i    (s_axis_tdata[15:0]),
    .data_i    (s_axis_tdata[23:16]),
    .cfg_i     (cfg_q),
    .ram_req_o (ram_req),
    .res_o     (res)
  );

  rrbc_ram #(
    .Width (DataW),
    .Depth (RamBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // merge the RAM byte into the staged result
    out_res_d = s1_res_q;
    if (s1_res_q.use_ram) begin
      out_res_d.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.read_data, out_res_q.rom_address};
  assign m_axis_tuser  = {out_res_q.unmapped, out_res_q.rom_access};

  // stalled stage keeps its item so the held RAM byte still matches it
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_res_q))
    else $error("stage register changed while stalled");

  a_read_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.re |=> s1_valid_q && s1_res_q.use_ram)
    else $error("RAM read issued without a staged RAM result");

  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("RAM read and write in the same cycle");

  a_unmapped_no_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("unmapped result marked as ROM access");

  a_rom_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[28:21] == '0)
    else $error("ROM access result carries read data");

endmodule
